>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the box blur RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst
`define BBR_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("box blur assertion failed");

// Next-cycle implication, sampled on clk, off during rst
`define BBR_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("box blur assertion failed");

`endif

>>> src/bbr_pkg.sv
// ----------------------------------------------------------------------------
// bbr_pkg
// Types, sizes and constants shared by the box blur modules.
// ----------------------------------------------------------------------------
package bbr_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 10;
  localparam int DIM_W       = 11;
  localparam int RAD_W       = 3;
  localparam int SLOT_W      = 5;               // row slots in the line store
  localparam int LS_AW       = SLOT_W + COL_W;
  localparam int LS_DEPTH    = 1 << LS_AW;
  localparam int PIX_W       = 24;
  localparam int CNT_W       = 21;              // linear pixel index, up to W*H
  localparam int LAG_W       = 14;              // r*W + r
  localparam int SUM_W       = 16;              // 225 * 255 fits
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 24;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int JOBQ_DEPTH  = 4;
  localparam int JOBQ_AW     = 2;

  // Register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  // Input item kinds
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [RAD_W-1:0] radius;
  } cfg_t;

  // One output pixel to compute
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } job_t;

  typedef struct packed {
    logic             en;
    logic [LS_AW-1:0] addr;
    logic [PIX_W-1:0] data;
  } wr_req_t;

  // ceil(2^24 / (2r+1)^2): exact floor division for sums below 2^24/(2r+1)^2
  function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] r);
    logic [RECIP_W-1:0] m;
    case (r)
      3'd0:    m = 25'd16777216;
      3'd1:    m = 25'd1864136;
      3'd2:    m = 25'd671089;
      3'd3:    m = 25'd342393;
      3'd4:    m = 25'd207127;
      3'd5:    m = 25'd138655;
      3'd6:    m = 25'd99274;
      3'd7:    m = 25'd74566;
      default: m = 25'd16777216;
    endcase
    return m;
  endfunction

endpackage

>>> src/box_blur_rgb_unit.sv
// ----------------------------------------------------------------------------
// box_blur_rgb_unit
// Streaming RGB box blur with a line store and a window engine.
// ----------------------------------------------------------------------------
// Input stream s_*: one transaction per item. s_tuser is the command
// (pixel or drain), s_tdata the pixel. Output stream m_*: one blurred
// pixel per transaction, m_tlast on the last pixel of the frame.
// Config port: cfg_we/cfg_addr/cfg_data set width, height and radius. A write
// restarts the frame. Issue it only while the block is idle; it is not enforced.
// An output pixel is queued by the item that brings the input r rows plus
// r pixels ahead of it; drain items release the rest at frame end.
// Each output pixel scans N entries in the window engine, N being the
// in-frame window size (1 up to 225 for radius 7): the engine reads one
// line-store entry per cycle through the single read port.
// Items are taken every cycle while the four-entry job queue has room.
// After the last output of a frame is queued, input holds until the
// engine has drained. When m_tready is low, the finished pixel waits in
// the output register and the engine and queue keep filling behind it.
// Reset: width 1024, height 1024, radius 1, frame position zero; the
// line store is not cleared, every entry is written before it is read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module box_blur_rgb_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
  input  logic        s_tuser,   // cmd [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
  output logic        m_tlast,   // frame_end
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [10:0] cfg_data
);

  bbr_pkg::cfg_t                 cfg;
  bbr_pkg::wr_req_t              wr;
  bbr_pkg::job_t                 job, q_dout;
  logic                          job_push, q_full, q_empty, pop, back_idle;
  logic                          draining, restart, rd_en;
  logic [bbr_pkg::LS_AW-1:0]     rd_addr;
  logic [bbr_pkg::PIX_W-1:0]     rd_data;
  logic [bbr_pkg::DIM_W-1:0]     dim_clamped;

  // Sizes are clamped to 1..1024 on write
  assign dim_clamped = (cfg_data == '0) ? bbr_pkg::DIM_W'(1)
                     : (cfg_data > bbr_pkg::DIM_W'(bbr_pkg::MAX_WIDTH))
                       ? bbr_pkg::DIM_W'(bbr_pkg::MAX_WIDTH) : cfg_data;

  assign restart = cfg_we && (cfg_addr == bbr_pkg::REG_WIDTH
                           || cfg_addr == bbr_pkg::REG_HEIGHT
                           || cfg_addr == bbr_pkg::REG_RADIUS);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= bbr_pkg::DIM_W'(bbr_pkg::MAX_WIDTH);
      cfg.height <= bbr_pkg::DIM_W'(bbr_pkg::MAX_HEIGHT);
      cfg.radius <= bbr_pkg::RAD_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        bbr_pkg::REG_WIDTH:  cfg.width  <= dim_clamped;
        bbr_pkg::REG_HEIGHT: cfg.height <= dim_clamped;
        bbr_pkg::REG_RADIUS: cfg.radius <= cfg_data[bbr_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  bbr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .restart   (restart),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .wr        (wr),
    .job       (job),
    .job_push  (job_push),
    .q_full    (q_full),
    .q_empty   (q_empty),
    .back_idle (back_idle),
    .draining  (draining)
  );

  bbr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job),
    .pop   (pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  // Line store: row slot x column
  bbr_ram #(
    .WIDTH (bbr_pkg::PIX_W),
    .DEPTH (bbr_pkg::LS_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  bbr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_dout    (q_dout),
    .q_empty   (q_empty),
    .pop       (pop),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .back_idle (back_idle)
  );

  // Checks
  `BBR_ASSERT_IMP(a_queue_no_overflow, job_push, !q_full)
  `BBR_ASSERT_IMP(a_store_no_clash, wr.en && rd_en, wr.addr != rd_addr)
  `BBR_ASSERT_NXT(a_hold_after_last, job_push && job.last, !s_tready)

endmodule

>>> src/bbr_ram.sv
// ----------------------------------------------------------------------------
// bbr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/bbr_queue.sv
// ----------------------------------------------------------------------------
// bbr_queue
// Short job queue between the front and the window engine.
// ----------------------------------------------------------------------------
module bbr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bbr_pkg::job_t din,
  input  logic          pop,
  output bbr_pkg::job_t dout,
  output logic          full,
  output logic          empty
);

  bbr_pkg::job_t                 slots [bbr_pkg::JOBQ_DEPTH];
  logic [bbr_pkg::JOBQ_AW-1:0]   wr_ptr;
  logic [bbr_pkg::JOBQ_AW-1:0]   rd_ptr;
  logic [bbr_pkg::JOBQ_AW:0]     count;

  assign full  = (count == (bbr_pkg::JOBQ_AW+1)'(bbr_pkg::JOBQ_DEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/bbr_front.sv
// ----------------------------------------------------------------------------
// bbr_front
// Accepts items, writes pixels to the line store and queues output jobs.
// ----------------------------------------------------------------------------
module bbr_front (
  input  logic             clk,
  input  logic             rst,
  input  bbr_pkg::cfg_t    cfg,
  input  logic             restart,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [23:0]      s_tdata,
  input  logic             s_tuser,
  output bbr_pkg::wr_req_t wr,
  output bbr_pkg::job_t    job,
  output logic             job_push,
  input  logic             q_full,
  input  logic             q_empty,
  input  logic             back_idle,
  output logic             draining
);

  logic [bbr_pkg::ROW_W-1:0] in_row, out_row;
  logic [bbr_pkg::COL_W-1:0] in_col, out_col;
  logic [bbr_pkg::CNT_W-1:0] n_in, o_idx, n_in_next, total;
  logic [bbr_pkg::LAG_W-1:0] lag;
  logic                      in_done, in_done_next;
  logic                      accept, take_px, in_col_wrap, in_row_wrap;
  logic                      out_col_wrap, is_last;

  assign s_tready = !draining && !q_full;
  assign accept   = s_tvalid && s_tready;
  assign take_px  = accept && (s_tuser == bbr_pkg::CMD_PIXEL) && !in_done;

  // Frame geometry
  assign total = bbr_pkg::CNT_W'(cfg.width) * bbr_pkg::CNT_W'(cfg.height);
  assign lag   = bbr_pkg::LAG_W'(cfg.radius) * bbr_pkg::LAG_W'(cfg.width)
               + bbr_pkg::LAG_W'(cfg.radius);

  assign in_col_wrap  = ({1'b0, in_col} + 1'b1) == cfg.width;
  assign in_row_wrap  = ({1'b0, in_row} + 1'b1) == cfg.height;
  assign out_col_wrap = ({1'b0, out_col} + 1'b1) == cfg.width;

  assign n_in_next    = n_in + bbr_pkg::CNT_W'(take_px);
  assign in_done_next = in_done || (take_px && in_col_wrap && in_row_wrap);

  // An output is due once the input is r rows plus r pixels ahead
  assign job_push = accept && (o_idx < total)
                 && (in_done_next || (o_idx + bbr_pkg::CNT_W'(lag)) < n_in_next);
  assign is_last  = (o_idx == total - 1'b1);

  assign job.row  = out_row;
  assign job.col  = out_col;
  assign job.last = is_last;

  // Line store write: row slot and column
  assign wr.en   = take_px;
  assign wr.addr = {in_row[bbr_pkg::SLOT_W-1:0], in_col};
  assign wr.data = s_tdata;

  // Position tracking
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_row   <= '0;
      in_col   <= '0;
      out_row  <= '0;
      out_col  <= '0;
      n_in     <= '0;
      o_idx    <= '0;
      in_done  <= 1'b0;
      draining <= 1'b0;
    end else begin
      if (take_px) begin
        n_in    <= n_in_next;
        in_done <= in_done_next;
        if (in_col_wrap) begin
          in_col <= '0;
          in_row <= in_row_wrap ? '0 : in_row + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (draining && q_empty && back_idle) begin
        draining <= 1'b0;
      end
      if (job_push) begin
        if (is_last) begin
          // frame done: hold input until the engine has drained
          in_row   <= '0;
          in_col   <= '0;
          out_row  <= '0;
          out_col  <= '0;
          n_in     <= '0;
          o_idx    <= '0;
          in_done  <= 1'b0;
          draining <= 1'b1;
        end else begin
          o_idx <= o_idx + 1'b1;
          if (out_col_wrap) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
    end
  end

endmodule

>>> src/bbr_back.sv
// ----------------------------------------------------------------------------
// bbr_back
// Window engine: scans the window in the line store, averages, outputs.
// ----------------------------------------------------------------------------
module bbr_back (
  input  logic                      clk,
  input  logic                      rst,
  input  bbr_pkg::cfg_t             cfg,
  input  bbr_pkg::job_t             q_dout,
  input  logic                      q_empty,
  output logic                      pop,
  output logic                      rd_en,
  output logic [bbr_pkg::LS_AW-1:0] rd_addr,
  input  logic [bbr_pkg::PIX_W-1:0] rd_data,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [23:0]               m_tdata,
  output logic                      m_tlast,
  output logic                      back_idle
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_TAIL = 5'b00100,
    S_MUL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                      state, state_next;
  logic [bbr_pkg::ROW_W-1:0]   k, k_hi, row_lo, row_hi;
  logic [bbr_pkg::COL_W-1:0]   l, l_lo, l_hi, col_lo, col_hi;
  logic [bbr_pkg::DIM_W-1:0]   row_sum, col_sum, h_max, w_max;
  logic [bbr_pkg::SUM_W-1:0]   acc_r, acc_g, acc_b;
  logic [bbr_pkg::PROD_W-1:0]  prod_r, prod_g, prod_b;
  logic [bbr_pkg::RECIP_W-1:0] m_recip;
  logic                        rd_vld, job_last;

  assign back_idle = (state == S_IDLE);
  assign pop       = (state == S_IDLE) && !q_empty;
  assign rd_en     = (state == S_SCAN);
  assign rd_addr   = {k[bbr_pkg::SLOT_W-1:0], l};
  assign m_recip   = bbr_pkg::recip(cfg.radius);

  // Window bounds clipped to the frame
  assign h_max   = cfg.height - 1'b1;
  assign w_max   = cfg.width - 1'b1;
  assign row_sum = {1'b0, q_dout.row} + bbr_pkg::DIM_W'(cfg.radius);
  assign col_sum = {1'b0, q_dout.col} + bbr_pkg::DIM_W'(cfg.radius);
  assign row_lo  = (q_dout.row >= bbr_pkg::ROW_W'(cfg.radius))
                 ? q_dout.row - bbr_pkg::ROW_W'(cfg.radius) : '0;
  assign col_lo  = (q_dout.col >= bbr_pkg::COL_W'(cfg.radius))
                 ? q_dout.col - bbr_pkg::COL_W'(cfg.radius) : '0;
  assign row_hi  = (row_sum > h_max) ? h_max[bbr_pkg::ROW_W-1:0]
                                     : row_sum[bbr_pkg::ROW_W-1:0];
  assign col_hi  = (col_sum > w_max) ? w_max[bbr_pkg::COL_W-1:0]
                                     : col_sum[bbr_pkg::COL_W-1:0];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (!q_empty) state_next = S_SCAN;
      S_SCAN: if (l == l_hi && k == k_hi) state_next = S_TAIL;
      S_TAIL: state_next = S_MUL;
      S_MUL:  state_next = S_OUT;
      S_OUT:  if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
    end
  end

  // Scan counters and channel sums (red in the low byte of a store entry)
  always_ff @(posedge clk) begin
    if (pop) begin
      k        <= row_lo;
      k_hi     <= row_hi;
      l        <= col_lo;
      l_lo     <= col_lo;
      l_hi     <= col_hi;
      job_last <= q_dout.last;
      acc_r    <= '0;
      acc_g    <= '0;
      acc_b    <= '0;
    end else begin
      if (state == S_SCAN) begin
        if (l == l_hi) begin
          l <= l_lo;
          k <= k + 1'b1;
        end else begin
          l <= l + 1'b1;
        end
      end
      if (rd_vld) begin
        acc_r <= acc_r + bbr_pkg::SUM_W'(rd_data[7:0]);
        acc_g <= acc_g + bbr_pkg::SUM_W'(rd_data[15:8]);
        acc_b <= acc_b + bbr_pkg::SUM_W'(rd_data[23:16]);
      end
    end
  end

  // Divide by the full (2r+1)^2 window size through its reciprocal
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod_r <= acc_r * m_recip;
      prod_g <= acc_g * m_recip;
      prod_b <= acc_b * m_recip;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {prod_b[bbr_pkg::RECIP_SHIFT+7:bbr_pkg::RECIP_SHIFT],
                  prod_g[bbr_pkg::RECIP_SHIFT+7:bbr_pkg::RECIP_SHIFT],
                  prod_r[bbr_pkg::RECIP_SHIFT+7:bbr_pkg::RECIP_SHIFT]};
      m_tlast <= job_last;
    end
  end

endmodule
